// ----- sv/bresenham_line_stepper_assert.svh -----
// Assertion helpers for the line stepper. Simulation builds see the
// checks; synthesis builds define SYNTH and get empty bodies.
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication check.
`define BLS_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line stepper check failed");

// Next-cycle implication check.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line stepper check failed");

`else

`define BLS_ASSERT(label, clk, rst_n, ante, cons)
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/bls_pkg.sv -----
`timescale 1ns / 1ps

package bls_pkg;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Direction and axis flags of the loaded line
  typedef struct packed {
    logic x_backward;
    logic y_backward;
    logic y_is_major;
  } line_dir_t;

endpackage

// ----- sv/bls_if.sv -----
`timescale 1ns / 1ps

interface bls_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

interface bls_out_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ----- sv/bls_load.sv -----
`timescale 1ns / 1ps

// Line setup: deltas, directions and major axis from the two endpoints.
module bls_load #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output bls_pkg::line_dir_t    dir,
  output logic [COORD_BITS-1:0] major_delta,
  output logic [COORD_BITS-1:0] minor_delta,
  output logic [COORD_BITS-1:0] stop_major
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  always_comb begin
    dir.x_backward = x_end < x_start;
    dir.y_backward = y_end < y_start;
    dx = dir.x_backward ? x_start - x_end : x_end - x_start;
    dy = dir.y_backward ? y_start - y_end : y_end - y_start;
    // ties go to y
    dir.y_is_major = dx <= dy;
    if (dir.y_is_major) begin
      major_delta = dy;
      minor_delta = dx;
      stop_major  = y_end;
    end else begin
      major_delta = dx;
      minor_delta = dy;
      stop_major  = x_end;
    end
  end

endmodule

// ----- sv/bls_step.sv -----
`timescale 1ns / 1ps

// One Bresenham step: major axis always moves, minor axis moves when
// twice the accumulated error passes the major delta.
module bls_step #(
  parameter int COORD_BITS = 12,
  parameter int ERR_BITS   = COORD_BITS + 2
) (
  input  logic [COORD_BITS-1:0]      cur_x,
  input  logic [COORD_BITS-1:0]      cur_y,
  input  logic signed [ERR_BITS-1:0] err_acc,
  input  logic [COORD_BITS-1:0]      major_delta,
  input  logic [COORD_BITS-1:0]      minor_delta,
  input  logic [COORD_BITS-1:0]      stop_major,
  input  bls_pkg::line_dir_t         dir,
  output logic [COORD_BITS-1:0]      next_x,
  output logic [COORD_BITS-1:0]      next_y,
  output logic signed [ERR_BITS-1:0] next_err,
  output logic                       done
);

  localparam int SUM_BITS = ERR_BITS + 1;
  localparam int DBL_BITS = ERR_BITS + 2;
  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic signed [SUM_BITS-1:0] err_sum;
  logic signed [DBL_BITS-1:0] err_dbl;
  logic signed [DBL_BITS-1:0] major_ext;
  logic                       minor_move;
  logic [COORD_BITS-1:0]      step_x;
  logic [COORD_BITS-1:0]      step_y;

  always_comb begin
    err_sum    = SUM_BITS'(err_acc) + $signed({{(SUM_BITS-COORD_BITS){1'b0}}, minor_delta});
    err_dbl    = DBL_BITS'(err_sum) <<< 1;
    major_ext  = $signed({{(DBL_BITS-COORD_BITS){1'b0}}, major_delta});
    minor_move = err_dbl > major_ext;

    step_x = dir.x_backward ? cur_x - ONE : cur_x + ONE;
    step_y = dir.y_backward ? cur_y - ONE : cur_y + ONE;

    if (minor_move) begin
      next_err = ERR_BITS'(err_sum - $signed({{(SUM_BITS-COORD_BITS){1'b0}}, major_delta}));
    end else begin
      next_err = ERR_BITS'(err_sum);
    end

    if (dir.y_is_major) begin
      next_y = step_y;
      next_x = minor_move ? step_x : cur_x;
      done   = step_y == stop_major;
    end else begin
      next_x = step_x;
      next_y = minor_move ? step_y : cur_y;
      done   = step_x == stop_major;
    end
  end

endmodule

// ----- sv/bresenham_line_stepper.sv -----
`timescale 1ns / 1ps

// Bresenham line stepper. A load item (op 0) sets up a line from start to
// end point; each step item (op 1) returns the next pixel, starting with
// the start point and stopping one short of the end point, with last_pixel
// set on the final one. Loads, zero-length lines and steps with no line in
// progress return nothing. The block takes one item per clock while the
// output is not held: a transfer lands in an input register, the setup or
// step logic works on it once the output register is free or being
// emptied, and writes the output register, from which the pixel then
// transfers out. The input register keeps taking one more item while a
// pixel waits on the output.
module bresenham_line_stepper #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_in_if.sink    in_s,
  bls_out_if.source out_m
);

  `include "bresenham_line_stepper_assert.svh"

  localparam int ERR_BITS = COORD_BITS + 2;

  // input register
  logic                  in_valid_r;
  logic                  op_r;
  logic [COORD_BITS-1:0] xs_r, ys_r, xe_r, ye_r;

  // output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic                  last_r;

  // line state
  logic [COORD_BITS-1:0]      cur_x_r, cur_y_r;
  logic [COORD_BITS-1:0]      stop_major_r, major_delta_r, minor_delta_r;
  logic signed [ERR_BITS-1:0] err_acc_r;
  bls_pkg::line_dir_t         dir_r;
  logic                       active_r;

  logic advance;
  logic do_load;
  logic do_step;

  bls_pkg::line_dir_t         ld_dir;
  logic [COORD_BITS-1:0]      ld_major, ld_minor, ld_stop;
  logic [COORD_BITS-1:0]      st_x, st_y;
  logic signed [ERR_BITS-1:0] st_err;
  logic                       st_done;

  assign advance    = !out_valid_r || out_m.ready;
  assign in_s.ready = !in_valid_r || advance;
  assign do_load    = in_valid_r && advance && (op_r == bls_pkg::OP_LOAD);
  assign do_step    = in_valid_r && advance && (op_r == bls_pkg::OP_STEP) && active_r;

  assign out_m.valid      = out_valid_r;
  assign out_m.pixel_x    = px_r;
  assign out_m.pixel_y    = py_r;
  assign out_m.last_pixel = last_r;

  bls_load #(.COORD_BITS(COORD_BITS)) u_load (
    .x_start     (xs_r),
    .y_start     (ys_r),
    .x_end       (xe_r),
    .y_end       (ye_r),
    .dir         (ld_dir),
    .major_delta (ld_major),
    .minor_delta (ld_minor),
    .stop_major  (ld_stop)
  );

  bls_step #(.COORD_BITS(COORD_BITS), .ERR_BITS(ERR_BITS)) u_step (
    .cur_x       (cur_x_r),
    .cur_y       (cur_y_r),
    .err_acc     (err_acc_r),
    .major_delta (major_delta_r),
    .minor_delta (minor_delta_r),
    .stop_major  (stop_major_r),
    .dir         (dir_r),
    .next_x      (st_x),
    .next_y      (st_y),
    .next_err    (st_err),
    .done        (st_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_s.valid && in_s.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      op_r <= in_s.op;
      xs_r <= in_s.x_start;
      ys_r <= in_s.y_start;
      xe_r <= in_s.x_end;
      ye_r <= in_s.y_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= do_step;
    end
  end

  // pixel is the position before the step
  always_ff @(posedge clk) begin
    if (do_step) begin
      px_r   <= cur_x_r;
      py_r   <= cur_y_r;
      last_r <= st_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      stop_major_r  <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      err_acc_r     <= '0;
      dir_r         <= '0;
      active_r      <= 1'b0;
    end else if (do_load) begin
      cur_x_r       <= xs_r;
      cur_y_r       <= ys_r;
      stop_major_r  <= ld_stop;
      major_delta_r <= ld_major;
      minor_delta_r <= ld_minor;
      err_acc_r     <= '0;
      dir_r         <= ld_dir;
      active_r      <= ld_major != '0;
    end else if (do_step) begin
      cur_x_r   <= st_x;
      cur_y_r   <= st_y;
      err_acc_r <= st_err;
      active_r  <= !st_done;
    end
  end

  `BLS_ASSERT(a_active_len, clk, rst_n, active_r, major_delta_r != '0)
  `BLS_ASSERT(a_minor_le_major, clk, rst_n, active_r, minor_delta_r <= major_delta_r)
  `BLS_ASSERT_NEXT(a_load_clears_err, clk, rst_n, do_load, err_acc_r == '0)
  `BLS_ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_r && !advance,
                   in_valid_r && $stable(op_r) && $stable(xs_r))

endmodule

// ----- bench/tb_bresenham_line_stepper.sv -----
`timescale 1ns / 1ps

module tb_bresenham_line_stepper;

  localparam int CB           = 12;
  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 60;
  localparam int PAUSE_AT     = 320;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic          op;
    logic [CB-1:0] x_start;
    logic [CB-1:0] y_start;
    logic [CB-1:0] x_end;
    logic [CB-1:0] y_end;
  } line_item_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
  } pixel_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIXEL} chk_kind_t;

  typedef struct packed {
    line_item_t item;
    chk_kind_t  kind;
    pixel_t     px;
  } dir_row_t;

  localparam int N_ROWS = 28;

  dir_row_t directed_rows [N_ROWS] = '{
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_LOAD, 12'd5, 12'd5, 12'd5, 12'd5}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd9, 12'd9, 12'd9, 12'd9}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_LOAD, 12'd0, 12'd0, 12'd1, 12'd0}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_PIXEL, '{12'd0, 12'd0, 1'b1}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_LOAD, 12'd0, 12'd0, 12'd0, 12'd1}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_PIXEL, '{12'd0, 12'd0, 1'b1}},
    '{'{bls_pkg::OP_LOAD, 12'd4095, 12'd4095, 12'd0, 12'd0}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_PIXEL, '{12'd4095, 12'd4095, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_LOAD, 12'd0, 12'd0, 12'd4095, 12'd0}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_PIXEL, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    // load over a line still in progress
    '{'{bls_pkg::OP_LOAD, 12'd0, 12'd4095, 12'd0, 12'd0}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_PIXEL, '{12'd0, 12'd4095, 1'b0}},
    '{'{bls_pkg::OP_LOAD, 12'd10, 12'd10, 12'd13, 12'd11}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_LOAD, 12'd100, 12'd200, 12'd97, 12'd202}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_MODEL, '0},
    '{'{bls_pkg::OP_LOAD, 12'd4095, 12'd0, 12'd0, 12'd4095}, CHK_NONE, '{12'd0, 12'd0, 1'b0}},
    '{'{bls_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0}, CHK_PIXEL, '{12'd4095, 12'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  bls_in_if  #(.COORD_BITS(CB)) in_ch ();
  bls_out_if #(.COORD_BITS(CB)) out_ch ();

  bresenham_line_stepper #(.COORD_BITS(CB)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  // line tracker state
  logic [CB-1:0]   trk_x;
  logic [CB-1:0]   trk_y;
  logic [CB-1:0]   trk_stop;
  logic [CB-1:0]   trk_major;
  logic [CB-1:0]   trk_minor;
  logic signed [CB+1:0] trk_err;
  bls_pkg::line_dir_t trk_dir;
  logic            trk_active;

  pixel_t pixels_due [$];
  int     errors;
  int     items_sent;
  bit     quiet;
  bit     hold_off_req;
  int     no_gap_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic advance_line(input line_item_t it, output bit emits, output pixel_t px);
    logic [CB-1:0] dx;
    logic [CB-1:0] dy;
    emits = 1'b0;
    px = '0;
    if (it.op == bls_pkg::OP_LOAD) begin
      trk_dir.x_backward = it.x_end < it.x_start;
      trk_dir.y_backward = it.y_end < it.y_start;
      dx = trk_dir.x_backward ? it.x_start - it.x_end : it.x_end - it.x_start;
      dy = trk_dir.y_backward ? it.y_start - it.y_end : it.y_end - it.y_start;
      trk_dir.y_is_major = dx <= dy;
      trk_major = trk_dir.y_is_major ? dy : dx;
      trk_minor = trk_dir.y_is_major ? dx : dy;
      trk_stop = trk_dir.y_is_major ? it.y_end : it.x_end;
      trk_x = it.x_start;
      trk_y = it.y_start;
      trk_err = '0;
      trk_active = trk_major != '0;
    end else if (trk_active) begin
      emits = 1'b1;
      px.x = trk_x;
      px.y = trk_y;
      trk_err = trk_err + $signed({2'b00, trk_minor});
      if (trk_dir.y_is_major) begin
        trk_y = trk_dir.y_backward ? trk_y - 1'b1 : trk_y + 1'b1;
        if (2 * int'(trk_err) > int'(trk_major)) begin
          trk_x = trk_dir.x_backward ? trk_x - 1'b1 : trk_x + 1'b1;
          trk_err = trk_err - $signed({2'b00, trk_major});
        end
        trk_active = trk_y != trk_stop;
      end else begin
        trk_x = trk_dir.x_backward ? trk_x - 1'b1 : trk_x + 1'b1;
        if (2 * int'(trk_err) > int'(trk_major)) begin
          trk_y = trk_dir.y_backward ? trk_y - 1'b1 : trk_y + 1'b1;
          trk_err = trk_err - $signed({2'b00, trk_major});
        end
        trk_active = trk_x != trk_stop;
      end
      px.last = !trk_active;
    end
  endtask

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send(input line_item_t it, input chk_kind_t kind, input pixel_t typed);
    bit     emits;
    pixel_t px;
    if (items_sent == HOLD_AT) begin
      hold_off_req = 1'b1;
      no_gap_left = 30;
    end
    if (items_sent == PAUSE_AT) begin
      in_ch.valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clk);
      @(posedge clk);
    end else if (!quiet && no_gap_left == 0 && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    if (no_gap_left > 0) no_gap_left--;
    in_ch.op      <= it.op;
    in_ch.x_start <= it.x_start;
    in_ch.y_start <= it.y_start;
    in_ch.x_end   <= it.x_end;
    in_ch.y_end   <= it.y_end;
    in_ch.valid   <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    advance_line(it, emits, px);
    case (kind)
      CHK_MODEL: if (emits) pixels_due = {pixels_due, px};
      CHK_PIXEL: pixels_due = {pixels_due, typed};
      default: ;
    endcase
  endtask

  function automatic logic [CB-1:0] near_coord(input logic [CB-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 48)) - 24;
    if (v < 0) v = 0;
    if (v > (1 << CB) - 1) v = (1 << CB) - 1;
    return v[CB-1:0];
  endfunction

  function automatic line_item_t rand_item();
    line_item_t it;
    it.op      = 1'($urandom);
    it.x_start = CB'($urandom);
    it.y_start = CB'($urandom);
    it.x_end   = CB'($urandom);
    it.y_end   = CB'($urandom);
    return it;
  endfunction

  task automatic send_steps(input int n);
    line_item_t it;
    for (int i = 0; i < n; i++) begin
      it = rand_item();
      it.op = bls_pkg::OP_STEP;
      send(it, CHK_MODEL, '0);
    end
  endtask

  task automatic send_short_line();
    line_item_t it;
    int major;
    int n;
    it.op = bls_pkg::OP_LOAD;
    it.x_start = CB'($urandom);
    it.y_start = CB'($urandom);
    it.x_end = near_coord(it.x_start);
    it.y_end = near_coord(it.y_start);
    send(it, CHK_MODEL, '0);
    major = int'(trk_major);
    n = major + int'($urandom_range(0, 2));
    // now and then cut the line short so the next load replaces it
    if ($urandom_range(0, 7) == 0) n = int'($urandom_range(0, major));
    send_steps(n);
  endtask

  // Receiver side
  initial begin
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pixel_x, out_ch.pixel_y, out_ch.last_pixel};
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected pixel: x=%0d y=%0d last=%0b", got.x, got.y, got.last);
      end else begin
        want = pixels_due.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.x, want.y, want.last, got.x, got.y, got.last);
        end
      end
    end
  end

  // Sender side and run control
  initial begin
    line_item_t it;
    int guard;
    int r;
    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    no_gap_left = 0;
    trk_x = '0;
    trk_y = '0;
    trk_stop = '0;
    trk_major = '0;
    trk_minor = '0;
    trk_err = '0;
    trk_dir = '0;
    trk_active = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = bls_pkg::OP_LOAD;
    in_ch.x_start = '0;
    in_ch.y_start = '0;
    in_ch.x_end = '0;
    in_ch.y_end = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send(directed_rows[i].item, directed_rows[i].kind, directed_rows[i].px);

    while (items_sent < N_ROWS + RANDOM_ITEMS) begin
      if (items_sent >= N_ROWS + RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      r = int'($urandom_range(0, 99));
      if (r < 75) begin
        send_short_line();
      end else if (r < 85) begin
        // long line, abandoned after a few pixels
        it = rand_item();
        it.op = bls_pkg::OP_LOAD;
        send(it, CHK_MODEL, '0);
        send_steps(int'($urandom_range(1, 12)));
      end else begin
        it = rand_item();
        send(it, CHK_MODEL, '0);
      end
    end
    in_ch.valid <= 1'b0;

    guard = 0;
    while (pixels_due.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pixels_due.size() != 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0d expected pixels never arrived", pixels_due.size());
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
